@@ design/bupe_pkg.sv @@
// Shared types and constants for the BGP UPDATE prefix extractor.
package bupe_pkg;

    localparam int ADDR_BITS      = 32;
    localparam int ADDR_BYTES     = ADDR_BITS / 8;
    localparam int BITS_W         = 6;
    localparam int KIND_W         = 2;
    localparam int POS_W          = 16;
    localparam int M_TDATA_W      = 40;

    // Header byte positions
    localparam logic [POS_W-1:0] POS_LEN_HI = 16'd16;
    localparam logic [POS_W-1:0] POS_LEN_LO = 16'd17;
    localparam logic [POS_W-1:0] POS_WD_HI  = 16'd19;
    localparam logic [POS_W-1:0] POS_WD_LO  = 16'd20;
    localparam logic [POS_W-1:0] POS_MAX    = 16'hFFFF;

    typedef enum logic [KIND_W-1:0] {
        KIND_WITHDRAWN = 2'd0,
        KIND_NLRI      = 2'd1,
        KIND_MALFORMED = 2'd2
    } prefix_kind_t;

endpackage

@@ design/bgp_update_prefix_extractor.sv @@
// Top level: byte-serial BGP UPDATE parser that emits withdrawn and NLRI prefixes.
// Output: a prefix result is registered and appears on the master side in the cycle after
//   the transfer of the byte that completes it.
// Throughput: one message byte per cycle; the parse state and the result register
//   update in the same cycle, so a stall only blocks while a result is still held.
// Reset: aresetn (synchronous, active low) clears the parse state to the header
//   phase at position zero and empties the result register.
module bgp_update_prefix_extractor (
    input  logic        aclk,
    input  logic        aresetn,
    // Input byte stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] msg_byte
    input  logic        s_axis_tuser,   // [0] first_byte
    // Prefix result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [bupe_pkg::M_TDATA_W-1:0] m_axis_tdata,
                                        // [5:0] prefix_bits, [37:6] prefix_addr, [39:38] zero
    output logic [bupe_pkg::KIND_W-1:0]    m_axis_tuser,   // [1:0] prefix_kind
    output logic        m_axis_tlast    // msg_done
);

    // Parse phases follow the field order of an UPDATE message.
    typedef enum logic [2:0] {
        PH_HDR     = 3'd0,
        PH_WD_LEN  = 3'd1,
        PH_WD_ADDR = 3'd2,
        PH_ATTR_HI = 3'd3,
        PH_ATTR_LO = 3'd4,
        PH_SKIP    = 3'd5,
        PH_NL_LEN  = 3'd6,
        PH_NL_ADDR = 3'd7
    } phase_t;

    localparam int PW = bupe_pkg::POS_W;
    localparam int AW = bupe_pkg::ADDR_BITS;
    localparam int BW = bupe_pkg::BITS_W;

    // Parse state
    logic [PW-1:0] byte_pos_reg,        byte_pos_next;
    phase_t        phase_reg,           phase_next;
    logic [PW-1:0] msg_length_reg,      msg_length_next;
    logic [PW-1:0] withdrawn_left_reg,  withdrawn_left_next;
    logic [PW-1:0] attr_skip_left_reg,  attr_skip_left_next;
    logic [2:0]    addr_bytes_left_reg, addr_bytes_left_next;
    logic [BW-1:0] cur_bits_reg,        cur_bits_next;
    logic [AW-1:0] addr_accum_reg,      addr_accum_next;

    // Result register
    logic          m_valid_reg;
    logic [1:0]    m_kind_reg;
    logic [BW-1:0] m_bits_reg;
    logic [AW-1:0] m_addr_reg;
    logic          m_done_reg;

    // Current state as seen by this byte (a first byte restarts the parse)
    logic [PW-1:0] pos_c, len_c, wd_c, skip_c;
    phase_t        phase_c;
    logic [2:0]    abl_c;
    logic [BW-1:0] bits_c;
    logic [AW-1:0] acc_c;

    logic          s_accept;
    logic [7:0]    b;
    logic [PW:0]   next_pos;
    logic [AW-1:0] acc_shift;
    logic [2:0]    abl_dec;
    logic [PW-1:0] wd_dec;
    logic [PW-1:0] skip_lo;
    logic [2:0]    len_bytes;

    logic          res_emit;
    logic [1:0]    res_kind;
    logic [BW-1:0] res_bits;
    logic [AW-1:0] res_addr;
    logic          res_done;

    // Left-align the accumulated bytes and clear bits past the prefix length.
    function automatic logic [AW-1:0] align_addr(input logic [AW-1:0] acc,
                                                  input logic [BW-1:0] bits);
        logic [6:0]    nb;
        logic [1:0]    pad_bytes;
        logic [AW-1:0] mask;
        nb        = ({1'b0, bits} + 7'd7) >> 3;
        pad_bytes = 2'(3'(bupe_pkg::ADDR_BYTES) - nb[2:0]);
        mask      = {AW{1'b1}} << (6'(AW) - bits);
        if (bits == '0) begin
            align_addr = '0;
        end else begin
            align_addr = (acc << {pad_bytes, 3'b000}) & mask;
        end
    endfunction

    assign s_axis_tready = !m_valid_reg || m_axis_tready;
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign b             = s_axis_tdata;

    always_comb begin
        // A first byte sees the reset state
        pos_c   = s_axis_tuser ? '0     : byte_pos_reg;
        phase_c = s_axis_tuser ? PH_HDR : phase_reg;
        len_c   = s_axis_tuser ? '0     : msg_length_reg;
        wd_c    = s_axis_tuser ? '0     : withdrawn_left_reg;
        skip_c  = s_axis_tuser ? '0     : attr_skip_left_reg;
        abl_c   = s_axis_tuser ? '0     : addr_bytes_left_reg;
        bits_c  = s_axis_tuser ? '0     : cur_bits_reg;
        acc_c   = s_axis_tuser ? '0     : addr_accum_reg;

        next_pos  = {1'b0, pos_c} + 1'b1;
        acc_shift = {acc_c[AW-9:0], b};
        abl_dec   = abl_c - 3'd1;
        wd_dec    = wd_c - 1'b1;
        skip_lo   = {skip_c[PW-1:8], b};
        len_bytes = 3'(({1'b0, b[5:0]} + 7'd7) >> 3);

        byte_pos_next        = (pos_c == bupe_pkg::POS_MAX) ? pos_c : next_pos[PW-1:0];
        phase_next           = phase_c;
        msg_length_next      = len_c;
        withdrawn_left_next  = wd_c;
        attr_skip_left_next  = skip_c;
        addr_bytes_left_next = abl_c;
        cur_bits_next        = bits_c;
        addr_accum_next      = acc_c;

        res_emit = 1'b0;
        res_kind = bupe_pkg::KIND_WITHDRAWN;
        res_bits = '0;
        res_addr = '0;
        res_done = 1'b0;

        unique case (phase_c)
            PH_HDR: begin
                if (pos_c == bupe_pkg::POS_LEN_HI) begin
                    msg_length_next = {b, len_c[7:0]};
                end else if (pos_c == bupe_pkg::POS_LEN_LO) begin
                    msg_length_next = {len_c[PW-1:8], b};
                end else if (pos_c == bupe_pkg::POS_WD_HI) begin
                    withdrawn_left_next = {b, wd_c[7:0]};
                end else if (pos_c >= bupe_pkg::POS_WD_LO) begin
                    withdrawn_left_next = {wd_c[PW-1:8], b};
                    phase_next = ({wd_c[PW-1:8], b} != '0) ? PH_WD_LEN : PH_ATTR_HI;
                end
            end
            PH_WD_LEN, PH_NL_LEN: begin
                // NLRI length bytes at or past the message end are dropped
                if (phase_c == PH_WD_LEN || pos_c < len_c) begin
                    if (b > 8'(AW)) begin
                        res_emit             = 1'b1;
                        res_kind             = bupe_pkg::KIND_MALFORMED;
                        res_done             = 1'b1;
                        msg_length_next      = '0;
                        withdrawn_left_next  = '0;
                        addr_bytes_left_next = '0;
                        cur_bits_next        = '0;
                        addr_accum_next      = '0;
                        phase_next           = PH_NL_LEN;
                    end else begin
                        cur_bits_next        = b[BW-1:0];
                        addr_accum_next      = '0;
                        addr_bytes_left_next = len_bytes;
                        if (len_bytes == '0) begin
                            // Zero-length prefix completes at once
                            res_emit = 1'b1;
                            res_bits = '0;
                            res_addr = '0;
                            if (phase_c == PH_NL_LEN) begin
                                res_kind   = bupe_pkg::KIND_NLRI;
                                res_done   = (next_pos >= {1'b0, len_c});
                                phase_next = PH_NL_LEN;
                            end else begin
                                res_kind            = bupe_pkg::KIND_WITHDRAWN;
                                withdrawn_left_next = wd_dec;
                                phase_next = (wd_dec != '0) ? PH_WD_LEN : PH_ATTR_HI;
                            end
                        end else begin
                            phase_next = (phase_c == PH_NL_LEN) ? PH_NL_ADDR : PH_WD_ADDR;
                        end
                    end
                end
            end
            PH_WD_ADDR, PH_NL_ADDR: begin
                addr_accum_next      = acc_shift;
                addr_bytes_left_next = abl_dec;
                if (abl_dec == '0) begin
                    res_emit = 1'b1;
                    res_bits = bits_c;
                    res_addr = align_addr(acc_shift, bits_c);
                    if (phase_c == PH_NL_ADDR) begin
                        res_kind   = bupe_pkg::KIND_NLRI;
                        res_done   = (next_pos >= {1'b0, len_c});
                        phase_next = PH_NL_LEN;
                    end else begin
                        res_kind            = bupe_pkg::KIND_WITHDRAWN;
                        withdrawn_left_next = wd_dec;
                        phase_next = (wd_dec != '0) ? PH_WD_LEN : PH_ATTR_HI;
                    end
                end
            end
            PH_ATTR_HI: begin
                attr_skip_left_next = {b, 8'h00};
                phase_next          = PH_ATTR_LO;
            end
            PH_ATTR_LO: begin
                attr_skip_left_next = skip_lo;
                phase_next          = (skip_lo != '0) ? PH_SKIP : PH_NL_LEN;
            end
            PH_SKIP: begin
                attr_skip_left_next = skip_c - 1'b1;
                if (skip_c - 1'b1 == '0) begin
                    phase_next = PH_NL_LEN;
                end
            end
            default: begin
                phase_next = phase_c;
            end
        endcase
    end

    // Parse state advances on every input transfer; the result register updates as noted below
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_pos_reg        <= '0;
            phase_reg           <= PH_HDR;
            msg_length_reg      <= '0;
            withdrawn_left_reg  <= '0;
            attr_skip_left_reg  <= '0;
            addr_bytes_left_reg <= '0;
            cur_bits_reg        <= '0;
            addr_accum_reg      <= '0;
            m_valid_reg         <= 1'b0;
            m_kind_reg          <= bupe_pkg::KIND_WITHDRAWN;
            m_bits_reg          <= '0;
            m_addr_reg          <= '0;
            m_done_reg          <= 1'b0;
        end else begin
            if (s_accept) begin
                byte_pos_reg        <= byte_pos_next;
                phase_reg           <= phase_next;
                msg_length_reg      <= msg_length_next;
                withdrawn_left_reg  <= withdrawn_left_next;
                attr_skip_left_reg  <= attr_skip_left_next;
                addr_bytes_left_reg <= addr_bytes_left_next;
                cur_bits_reg        <= cur_bits_next;
                addr_accum_reg      <= addr_accum_next;
            end
            // Result register loads whenever it is empty or being drained
            if (s_axis_tready) begin
                m_valid_reg <= s_accept && res_emit;
            end
            // Result payload: hold until a new result is loaded
            if (s_accept && res_emit) begin
                m_kind_reg <= res_kind;
                m_bits_reg <= res_bits;
                m_addr_reg <= res_addr;
                m_done_reg <= res_done;
            end
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {2'b00, m_addr_reg, m_bits_reg};
    assign m_axis_tuser  = m_kind_reg;
    assign m_axis_tlast  = m_done_reg;

endmodule
